[src/wsfe_pkg.sv]
// wsfe_pkg: shared types, constants and header byte functions for the
// websocket frame encoder; no dependencies
package wsfe_pkg;

	// item kind carried in tuser
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [7:0]  HDR_TEXT_FIN = 8'h81;
	localparam logic [7:0]  MASKED_FLAG  = 8'h80;
	localparam logic [30:0] LEN7_MAX     = 31'd125;
	localparam logic [7:0]  LEN16_CODE   = 8'd126;
	localparam logic [7:0]  LEN64_CODE   = 8'd127;
	localparam logic [30:0] LEN16_MAX    = 31'h0000ffff;

	// length field format of a frame header
	typedef enum logic [1:0] {
		LC_SHORT,
		LC_MID,
		LC_LONG
	} len_class_t;

	// one queued command: a whole header or one masked payload byte
	typedef struct packed {
		logic        is_hdr;
		len_class_t  cls;
		logic [30:0] len;
		logic [31:0] key;
		logic [7:0]  pay_byte;
		logic        last;
	} cmd_t;

	// first key byte sits in the top bits
	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
		logic [7:0] b;
		begin
			case (phase)
				2'd0:    b = key[31:24];
				2'd1:    b = key[23:16];
				2'd2:    b = key[15:8];
				default: b = key[7:0];
			endcase
			return b;
		end
	endfunction

	// index of the final header byte
	function automatic logic [3:0] hdr_last(input len_class_t cls);
		logic [3:0] n;
		begin
			unique case (cls)
				LC_SHORT: n = 4'd5;
				LC_MID:   n = 4'd7;
				LC_LONG:  n = 4'd13;
				default:  n = 4'd5;
			endcase
			return n;
		end
	endfunction

	// header byte at position idx
	function automatic logic [7:0] hdr_byte(input len_class_t cls, input logic [30:0] len,
			input logic [31:0] key, input logic [3:0] idx);
		logic [3:0] key_base;
		logic [3:0] kidx;
		logic [7:0] b;
		begin
			key_base = hdr_last(cls) - 4'd3;
			kidx = idx - key_base;
			b = 8'h00;
			if (idx == 4'd0) begin
				b = HDR_TEXT_FIN;
			end else if (idx >= key_base) begin
				b = key_byte(key, kidx[1:0]);
			end else begin
				unique case (cls)
					LC_SHORT: b = MASKED_FLAG | {1'b0, len[6:0]};
					LC_MID: begin
						case (idx)
							4'd1:    b = MASKED_FLAG | LEN16_CODE;
							4'd2:    b = len[15:8];
							default: b = len[7:0];
						endcase
					end
					LC_LONG: begin
						case (idx)
							4'd1:    b = MASKED_FLAG | LEN64_CODE;
							4'd6:    b = {1'b0, len[30:24]};
							4'd7:    b = len[23:16];
							4'd8:    b = len[15:8];
							4'd9:    b = len[7:0];
							default: b = 8'h00;
						endcase
					end
					default: b = 8'h00;
				endcase
			end
			return b;
		end
	endfunction

endpackage

[src/websocket_frame_encoder.sv]
// websocket_frame_encoder: masked client text frame encoder, top level
// path: an accepted input beat is written to the command queue, then to the output register
// throughput: one payload beat per cycle while m_tready allows; a start beat holds the back end for
// 6, 8 or 14 header bytes (short, 16-bit or 64-bit length header)
// input stalls only while the QUEUE_DEPTH command queue is full
// reset: arst_n clears frame state, queue and output valid asynchronously
module websocket_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // msg_length[30:0], mask_key[62:31], payload_byte[70:63], zero
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast
);
	import wsfe_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_ready;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// front: classify and mask
	wsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.kind         (s_tuser),
		.msg_length   (s_tdata[30:0]),
		.mask_key     (s_tdata[62:31]),
		.payload_byte (s_tdata[70:63]),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_ready      (q_ready)
	);

	// command queue
	wsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (q_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// back: byte sequencer and output register
	wsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

[src/wsfe_front.sv]
// wsfe_front: accepts input beats, tracks the open frame and masks payload
// depends on wsfe_pkg
module wsfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [30:0]      msg_length,
	input  logic [31:0]      mask_key,
	input  logic [7:0]       payload_byte,
	output logic             push,
	output wsfe_pkg::cmd_t   push_cmd,
	input  logic             q_ready
);
	import wsfe_pkg::*;

	logic [31:0] key_q;
	logic [30:0] left_q;
	logic [1:0]  phase_q;
	logic        accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	// payload with no frame open is dropped
	assign push = accept && ((kind == KIND_START) || (left_q != 31'd0));

	// build the command for the queue
	always_comb begin
		push_cmd = '0;
		if (kind == KIND_START) begin
			push_cmd.is_hdr = 1'b1;
			push_cmd.len    = msg_length;
			push_cmd.key    = mask_key;
			if (msg_length <= LEN7_MAX)
				push_cmd.cls = LC_SHORT;
			else if (msg_length <= LEN16_MAX)
				push_cmd.cls = LC_MID;
			else
				push_cmd.cls = LC_LONG;
		end else begin
			push_cmd.is_hdr   = 1'b0;
			push_cmd.cls      = LC_SHORT;
			push_cmd.pay_byte = payload_byte ^ key_byte(key_q, phase_q);
			push_cmd.last     = (left_q == 31'd1);
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			left_q  <= '0;
			phase_q <= '0;
		end else if (push) begin
			if (kind == KIND_START) begin
				key_q   <= mask_key;
				left_q  <= msg_length;
				phase_q <= 2'd0;
			end else begin
				left_q  <= left_q - 31'd1;
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

[src/wsfe_queue.sv]
// wsfe_queue: short command queue between front and back
// depends on wsfe_pkg
module wsfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wsfe_pkg::cmd_t   push_cmd,
	output logic             push_ready,
	output logic             head_valid,
	output wsfe_pkg::cmd_t   head_cmd,
	input  logic             pop
);
	import wsfe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count above depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");
`endif

endmodule

[src/wsfe_back.sv]
// wsfe_back: walks header commands byte by byte, passes payload bytes and drives the output register
// depends on wsfe_pkg
module wsfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  wsfe_pkg::cmd_t   head_cmd,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import wsfe_pkg::*;

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       advance;
	logic       emit;
	logic       hdr_done;
	logic [7:0] next_byte;
	logic       next_last;

	assign advance  = !out_valid_q || out_ready;
	assign emit     = head_valid && advance;
	assign hdr_done = (idx_q == hdr_last(head_cmd.cls));
	assign pop      = emit && (!head_cmd.is_hdr || hdr_done);

	// select the beat to emit
	always_comb begin
		if (head_cmd.is_hdr) begin
			next_byte = hdr_byte(head_cmd.cls, head_cmd.len, head_cmd.key, idx_q);
			next_last = hdr_done && (head_cmd.len == 31'd0);
		end else begin
			next_byte = head_cmd.pay_byte;
			next_last = head_cmd.last;
		end
	end

	// header byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (emit && head_cmd.is_hdr)
			idx_q <= hdr_done ? 4'd0 : idx_q + 4'd1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_idx_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 4'd0 |-> head_valid && head_cmd.is_hdr)
		else $error("header counter running without a header at the head");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head_cmd.is_hdr |-> idx_q <= hdr_last(head_cmd.cls))
		else $error("header counter past the last header byte");
`endif

endmodule
